/* sv/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define FFHA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define FFHA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/ffha_pkg.sv */
// types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int unsigned REQ_W    = 18;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLACK_W  = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = 32'hC000_0000;
  localparam logic [SLACK_W-1:0] SLACK_RST     = 12'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SLACK = 1'b1;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

/* sv/first_fit_heap_allocator_core.sv */
// first-fit heap allocator with block splitting, segment table in one memory
//
// usage
//   request word on in_*: operation (allocate or free), request_bytes for an
//   allocate, block_address for a free. one result word on out_*: the granted
//   address (zero unless allocated) and a status code.
//   configuration (heap base, split slack) through cfg_we_i while idle.
// request handling
//   one request at a time. the chain of segments is walked through the
//   segment memory, a read state and then a check state per visited segment;
//   a hit that splits its segment passes a split state before the done state,
//   a miss ends when the chain runs out, a null free goes straight to done.
//   a new request is taken as soon as the previous result sits in the output
//   register, even if the receiver has not yet taken it.
// reset
//   one free segment covering the heap less one header; entry 0 is supplied
//   by a flag until first written, so no clearing pass is needed.
// stall
//   a result waits in the done state while the output register is full and not being taken
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_core #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned HEAP_BYTES   = 131072,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic [ffha_pkg::REQ_W-1:0]          request_bytes_i,
  input  wire logic [ffha_pkg::ADDR_W-1:0]         block_address_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ffha_pkg::ADDR_W-1:0]              granted_address_o,
  output logic [ffha_pkg::STATUS_W-1:0]            status_o,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ffha_pkg::ADDR_W-1:0]         cfg_data_i
);

  // segment index incl. end marker, memory address, byte offsets, request size, compare width
  localparam int unsigned IW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned NW = ffha_pkg::REQ_W + 1;
  localparam int unsigned CW = ((SW > NW) ? SW : NW) + 2;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
    logic [IW-1:0] next;
  } seg_t;

  // segment memory, one write and one registered read per cycle
  seg_t seg_mem_q [MAX_SEGMENTS];
  seg_t rd_q;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  seg_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= seg_mem_q[mem_raddr];
    end
  end

  ffha_pkg::state_e state_q, state_d;
  logic                           op_q, op_d;
  logic [NW-1:0]                  need_q, need_d;
  logic [ffha_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [IW-1:0]                  cur_q, cur_d;
  logic [IW-1:0]                  steps_q, steps_d;
  logic [IW-1:0]                  cnt_q, cnt_d;
  logic                           init0_q, init0_d;
  logic [ffha_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic [ffha_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic                           out_valid_q, out_valid_d;
  logic [ffha_pkg::ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [ffha_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [ffha_pkg::ADDR_W-1:0]    heap_base_q;
  logic [ffha_pkg::SLACK_W-1:0]   slack_q;

  seg_t                        rst_seg;
  seg_t                        ent;
  logic                        link_ok;
  logic                        fits;
  logic                        do_split;
  logic [CW-1:0]               size_c;
  logic [CW-1:0]               need_c;
  logic [CW-1:0]               split_lim;
  logic [ffha_pkg::ADDR_W-1:0] user_addr;
  logic [NW-1:0]               req_round;
  logic                        in_fire;
  logic                        out_load;

  // segment 0 as it stands after reset
  always_comb begin
    rst_seg.start = '0;
    rst_seg.size  = SW'(HEAP_BYTES - HEADER_BYTES);
    rst_seg.free  = 1'b1;
    rst_seg.next  = IW'(MAX_SEGMENTS);
  end

  // entry 0 comes from the reset value until it is first written
  assign ent       = ((cur_q == '0) && init0_q) ? rst_seg : rd_q;
  assign link_ok   = (cur_q < cnt_q) && (steps_q < IW'(MAX_SEGMENTS));
  assign size_c    = CW'(ent.size);
  assign need_c    = CW'(need_q);
  assign split_lim = need_c + CW'(HEADER_BYTES) + CW'(slack_q);
  assign fits      = ent.free && (size_c >= need_c);
  assign do_split  = (size_c > split_lim) && (cnt_q < IW'(MAX_SEGMENTS));
  assign user_addr = heap_base_q + ffha_pkg::ADDR_W'(ent.start)
                   + ffha_pkg::ADDR_W'(HEADER_BYTES);

  // round the request up to a multiple of four bytes
  assign req_round = (NW'(request_bytes_i) + NW'(3)) & ~NW'(3);

  assign in_ready_o = (state_q == ffha_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = !out_valid_q || out_ready_i;
  assign mem_raddr  = cur_q[AW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    need_d       = need_q;
    addr_d       = addr_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    cnt_d        = cnt_q;
    init0_d      = init0_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_q[AW-1:0];
    mem_wdata    = ent;

    case (state_q)
      ffha_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d       = operation_i;
          need_d     = req_round;
          addr_d     = block_address_i;
          cur_d      = '0;
          steps_d    = '0;
          res_addr_d = '0;
          if ((operation_i == ffha_pkg::OP_FREE) && (block_address_i == '0)) begin
            res_status_d = ffha_pkg::ST_NULL;
            state_d      = ffha_pkg::S_DONE;
          end else begin
            state_d = ffha_pkg::S_READ;
          end
        end
      end

      ffha_pkg::S_READ: begin
        if (link_ok) begin
          mem_re  = 1'b1;
          state_d = ffha_pkg::S_CHECK;
        end else begin
          // chain exhausted without a hit
          res_addr_d   = '0;
          res_status_d = (op_q == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_MEM
                                                       : ffha_pkg::ST_NOT_FOUND;
          state_d      = ffha_pkg::S_DONE;
        end
      end

      ffha_pkg::S_CHECK: begin
        if (op_q == ffha_pkg::OP_ALLOC) begin
          if (fits) begin
            res_addr_d   = user_addr;
            res_status_d = ffha_pkg::ST_ALLOC;
            if (do_split) begin
              // remainder becomes a new free segment at the end of the table
              mem_we          = 1'b1;
              mem_waddr       = cnt_q[AW-1:0];
              mem_wdata.start = ent.start + SW'(HEADER_BYTES) + SW'(need_q);
              mem_wdata.size  = ent.size - SW'(need_q) - SW'(HEADER_BYTES);
              mem_wdata.free  = 1'b1;
              mem_wdata.next  = ent.next;
              state_d         = ffha_pkg::S_SPLIT;
            end else begin
              mem_we         = 1'b1;
              mem_wdata.free = 1'b0;
              if (cur_q == '0) begin
                init0_d = 1'b0;
              end
              state_d = ffha_pkg::S_DONE;
            end
          end else begin
            cur_d   = ent.next;
            steps_d = steps_q + IW'(1);
            state_d = ffha_pkg::S_READ;
          end
        end else begin
          if (user_addr == addr_q) begin
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
            if (cur_q == '0) begin
              init0_d = 1'b0;
            end
            res_addr_d   = '0;
            res_status_d = ffha_pkg::ST_FREED;
            state_d      = ffha_pkg::S_DONE;
          end else begin
            cur_d   = ent.next;
            steps_d = steps_q + IW'(1);
            state_d = ffha_pkg::S_READ;
          end
        end
      end

      ffha_pkg::S_SPLIT: begin
        // shrink the taken segment and link it to the new one
        mem_we         = 1'b1;
        mem_wdata.size = SW'(need_q);
        mem_wdata.free = 1'b0;
        mem_wdata.next = cnt_q;
        cnt_d          = cnt_q + IW'(1);
        if (cur_q == '0) begin
          init0_d = 1'b0;
        end
        state_d = ffha_pkg::S_DONE;
      end

      ffha_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = ffha_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_IDLE;
      cnt_q       <= IW'(1);
      init0_q     <= 1'b1;
      out_valid_q <= 1'b0;
      heap_base_q <= ffha_pkg::HEAP_BASE_RST;
      slack_q     <= ffha_pkg::SLACK_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init0_q     <= init0_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ffha_pkg::CFG_HEAP_BASE) begin
          heap_base_q <= cfg_data_i;
        end
        if (cfg_idx_i == ffha_pkg::CFG_SPLIT_SLACK) begin
          slack_q <= cfg_data_i[ffha_pkg::SLACK_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    need_q       <= need_d;
    addr_q       <= addr_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

endmodule

`default_nettype wire

/* sv/ffha_checker.sv */
// port-level checks of the heap allocator and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ffha_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [ffha_pkg::ADDR_W-1:0]        granted_address_o,
  input wire logic [ffha_pkg::STATUS_W-1:0]      status_o
);

  // only a successful allocate carries an address
  `FFHA_ASSERT_NEVER(a_addr_zero, clk_i, rst_ni, out_valid_o && (status_o != ffha_pkg::ST_ALLOC) && (granted_address_o != '0), "address on a word that is not an allocation")

  // an accepted request keeps the block busy in the following cycle
  `FFHA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while previous one in flight")

  // a stalled result word is held
  `FFHA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped while stalled")

  `FFHA_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(granted_address_o), "result word changed while stalled")

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .granted_address_o (granted_address_o),
  .status_o          (status_o)
);

`default_nettype wire
